// ===== src/srsm_pkg.sv =====
package srsm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = PATTERN_MAX + 1;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_BYTES_LOW      = 3'd1,
    REG_BYTES_HIGH     = 3'd2,
    REG_ANY_BYTE_MASK  = 3'd3,
    REG_REPEAT_MASK    = 3'd4,
    REG_ANCHOR_START   = 3'd5,
    REG_ANCHOR_END     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  pattern_length;
    logic [63:0] element_bytes_low;
    logic [63:0] element_bytes_high;
    logic [15:0] any_byte_mask;
    logic [15:0] repeat_mask;
    logic        anchor_start;
    logic        anchor_end;
  } cfg_t;

endpackage

// ===== src/srsm_regs.sv =====
module srsm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsm_pkg::DATA_W-1:0]   pwdata,
  output logic [srsm_pkg::DATA_W-1:0]   prdata,
  output srsm_pkg::cfg_t                cfg
);

  logic            wr_en;
  logic [2:0]      idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (srsm_pkg::reg_idx_t'(idx))
        srsm_pkg::REG_PATTERN_LENGTH: cfg.pattern_length     <= pwdata[4:0];
        srsm_pkg::REG_BYTES_LOW:      cfg.element_bytes_low  <= pwdata;
        srsm_pkg::REG_BYTES_HIGH:     cfg.element_bytes_high <= pwdata;
        srsm_pkg::REG_ANY_BYTE_MASK:  cfg.any_byte_mask      <= pwdata[15:0];
        srsm_pkg::REG_REPEAT_MASK:    cfg.repeat_mask        <= pwdata[15:0];
        srsm_pkg::REG_ANCHOR_START:   cfg.anchor_start       <= pwdata[0];
        srsm_pkg::REG_ANCHOR_END:     cfg.anchor_end         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (srsm_pkg::reg_idx_t'(idx))
      srsm_pkg::REG_PATTERN_LENGTH: prdata = {59'd0, cfg.pattern_length};
      srsm_pkg::REG_BYTES_LOW:      prdata = cfg.element_bytes_low;
      srsm_pkg::REG_BYTES_HIGH:     prdata = cfg.element_bytes_high;
      srsm_pkg::REG_ANY_BYTE_MASK:  prdata = {48'd0, cfg.any_byte_mask};
      srsm_pkg::REG_REPEAT_MASK:    prdata = {48'd0, cfg.repeat_mask};
      srsm_pkg::REG_ANCHOR_START:   prdata = {63'd0, cfg.anchor_start};
      srsm_pkg::REG_ANCHOR_END:     prdata = {63'd0, cfg.anchor_end};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== src/srsm_core.sv =====
module srsm_core (
  input  logic           clk,
  input  logic           rst,
  input  srsm_pkg::cfg_t cfg,
  input  logic           step,
  input  logic           kind,
  input  logic [7:0]     text_byte,
  output logic           result
);

  logic [srsm_pkg::POS_W-1:0] active_positions;
  logic [srsm_pkg::POS_W-1:0] active_positions_next;
  logic                       found_so_far;
  logic                       found_so_far_next;
  logic                       before_first_byte;
  logic                       before_first_byte_next;

  logic [srsm_pkg::LEN_W-1:0] len;
  logic [srsm_pkg::POS_W-1:0] len_mask;
  logic [srsm_pkg::POS_W-1:0] seed;
  logic [srsm_pkg::POS_W-1:0] cur_set;
  logic [srsm_pkg::POS_W-1:0] next_set;
  logic [127:0]               elem_bytes;
  logic                       at_end;

  assign len = (cfg.pattern_length > srsm_pkg::LEN_W'(srsm_pkg::PATTERN_MAX)) ?
               srsm_pkg::LEN_W'(srsm_pkg::PATTERN_MAX) : cfg.pattern_length;
  assign elem_bytes = {cfg.element_bytes_high, cfg.element_bytes_low};

  always_comb begin
    for (int q = 0; q < srsm_pkg::POS_W; q++) begin
      len_mask[q] = (q <= int'(len));
    end
  end

  // a fresh start is injected unless anchored past the first byte
  assign seed = active_positions |
                {{(srsm_pkg::POS_W-1){1'b0}}, before_first_byte || !cfg.anchor_start};

  // skip closure: q reachable from any seeded p through a run of starred elements
  always_comb begin
    logic run;
    logic hit;
    for (int q = 0; q < srsm_pkg::POS_W; q++) begin
      run = 1'b1;
      hit = 1'b0;
      for (int p = q; p >= 0; p--) begin
        if (p < q) begin
          run = run & cfg.repeat_mask[p];
        end
        hit = hit | (seed[p] & run);
      end
      cur_set[q] = hit & len_mask[q];
    end
  end

  assign at_end = cur_set[len];

  always_comb begin
    logic hit;
    next_set = '0;
    for (int p = 0; p < srsm_pkg::PATTERN_MAX; p++) begin
      hit = cfg.any_byte_mask[p] || (elem_bytes[p*8 +: 8] == text_byte);
      if ((p < int'(len)) && cur_set[p] && hit) begin
        if (cfg.repeat_mask[p]) begin
          next_set[p] = 1'b1;
        end else begin
          next_set[p+1] = 1'b1;
        end
      end
    end
  end

  assign result = cfg.anchor_end ? at_end : (found_so_far | at_end);

  always_comb begin
    active_positions_next  = active_positions;
    found_so_far_next      = found_so_far;
    before_first_byte_next = before_first_byte;
    if (step) begin
      if (kind == srsm_pkg::KIND_END) begin
        active_positions_next  = '0;
        found_so_far_next      = 1'b0;
        before_first_byte_next = 1'b1;
      end else begin
        active_positions_next  = next_set;
        found_so_far_next      = found_so_far | (!cfg.anchor_end && at_end);
        before_first_byte_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions  <= '0;
      found_so_far      <= 1'b0;
      before_first_byte <= 1'b1;
    end else begin
      active_positions  <= active_positions_next;
      found_so_far      <= found_so_far_next;
      before_first_byte <= before_first_byte_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && kind == srsm_pkg::KIND_END |=>
      active_positions == '0 && !found_so_far && before_first_byte)
    else $error("text state not cleared after end item");

  a_byte_leaves_start: assert property (@(posedge clk) disable iff (rst)
    step && kind == srsm_pkg::KIND_BYTE |=> !before_first_byte)
    else $error("start flag still set after a text byte");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    found_so_far && !(step && kind == srsm_pkg::KIND_END) |=> found_so_far)
    else $error("found flag dropped within a text");

  a_found_needs_end: assert property (@(posedge clk) disable iff (rst)
    step && kind == srsm_pkg::KIND_BYTE && !found_so_far && !at_end |=> !found_so_far)
    else $error("found flag set without a full match");

endmodule

// ===== src/simple_regex_stream_matcher.sv =====
// Streaming matcher for a small regular expression (literal bytes, '.', starred
// elements, start and end anchors) held in registers. One text byte is taken per
// cycle while no end item is held back. An item sits in the input register while
// the set of active positions is updated; an end item's result is then registered.
// A byte item gives no result; an end item gives one found bit and starts a new
// text. A waiting result holds back the next end item, and the items behind it,
// until the result is taken; text bytes ahead of that end item never wait.
// Write the pattern registers only while no text is in flight.
module simple_regex_stream_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsm_pkg::ADDR_W-1:0] paddr,
  input  logic [srsm_pkg::DATA_W-1:0] pwdata,
  output logic [srsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [7:0]                  text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found
);

  srsm_pkg::cfg_t cfg;
  logic           in_valid_q;
  logic           kind_q;
  logic [7:0]     byte_q;
  logic           step;
  logic           result;

  assign pready = 1'b1;

  srsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // an end item moves on only when the result slot is free or being emptied
  assign step = in_valid_q &&
                (kind_q == srsm_pkg::KIND_BYTE || !out_valid || out_ready);
  assign in_ready = !in_valid_q || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_q <= kind;
      byte_q <= text_byte;
    end
  end

  srsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .kind      (kind_q),
    .text_byte (byte_q),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && kind_q == srsm_pkg::KIND_END) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && kind_q == srsm_pkg::KIND_END) begin
      found <= result;
    end
  end

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid_q |-> in_ready)
    else $error("input stage empty but not ready");

  a_end_blocked: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && kind_q == srsm_pkg::KIND_END && out_valid && !out_ready |-> !in_ready)
    else $error("end item passed a stalled result");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step) && $past(kind_q) == srsm_pkg::KIND_END)
    else $error("result without an end item");

endmodule
